// ===== src/cvcdc_pkg.sv =====
package cvcdc_pkg;

  localparam int GAIN_W     = 24;
  localparam int LIMIT_W    = 15;
  localparam int DUTY_W     = 16;
  localparam int OUT_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [DUTY_W-1:0] DUTY_HALF = 16'h8000;

  // Vref and limit resets in whole units, scaled to the sample format at elaboration
  localparam int RST_VREF_UNITS = -12;
  localparam int RST_ILIM_UNITS = 2;
  localparam int RST_CLIM_UNITS = 5;
  localparam logic [GAIN_W-1:0] RST_KP_V   = 24'd1677722;
  localparam logic [GAIN_W-1:0] RST_KI_V   = 24'd2517;
  localparam logic [GAIN_W-1:0] RST_KP_I   = 24'd838861;
  localparam logic [DUTY_W-1:0] RST_DUTY_MAX = 16'd58982;
  localparam logic [DUTY_W-1:0] RST_DUTY_MIN = 16'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOLTAGE_REFERENCE = 3'd0,
    REG_VOLTAGE_PROP_GAIN = 3'd1,
    REG_VOLTAGE_INT_GAIN  = 3'd2,
    REG_CURRENT_PROP_GAIN = 3'd3,
    REG_INTEGRAL_LIMIT    = 3'd4,
    REG_CURRENT_LIMIT     = 3'd5,
    REG_DUTY_MAXIMUM      = 3'd6,
    REG_DUTY_MINIMUM      = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    GAIN_KI  = 2'd0,
    GAIN_KP  = 2'd1,
    GAIN_KPI = 2'd2
  } gain_sel_e;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MI   = 7'b0000010,
    S_INT  = 7'b0000100,
    S_REF  = 7'b0001000,
    S_CERR = 7'b0010000,
    S_MC   = 7'b0100000,
    S_DUTY = 7'b1000000
  } state_e;

  // Width-fixed configuration; the voltage reference travels apart
  typedef struct packed {
    logic [GAIN_W-1:0]  kp_v;
    logic [GAIN_W-1:0]  ki_v;
    logic [GAIN_W-1:0]  kp_i;
    logic [LIMIT_W-1:0] int_limit;
    logic [LIMIT_W-1:0] cur_limit;
    logic [DUTY_W-1:0]  duty_ceil;
    logic [DUTY_W-1:0]  duty_floor;
  } cfg_t;

  typedef struct packed {
    logic      load_in;
    logic      mul_en;
    logic      mul_cerr;
    gain_sel_e gain_sel;
    logic      int_en;
    logic      ref_en;
    logic      cerr_en;
    logic      out_en;
  } ctrl_t;

endpackage

// ===== src/cascaded_voltage_current_duty_control.sv =====
// Channel   Direction  Handshake               Payload
// in        sink       in_valid / in_stall     output_voltage, coil_current
// out       source     out_valid / out_stall   duty_cycle, current_reference,
//                                              integral_saturated, duty_saturated
// cfg       sink       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// An item passes through S_MI, S_INT, S_REF, S_CERR, S_MC and S_DUTY before
// its result loads; the next item can be taken the cycle after the result loads.
// The block has a single multiplier, used three times per item
// (ki and kp on the voltage error, kp_i on the current error).
// A result waiting under out_stall does not block the next item; the block
// holds its last step only if a second result would overwrite the first.
// rst is synchronous: clears the integral, loads register defaults, empties out.
module cascaded_voltage_current_duty_control import cvcdc_pkg::*; #(
  parameter int SAMPLE_WIDTH       = 16,
  parameter int GAIN_FRACTION_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] output_voltage,
  input  logic signed [SAMPLE_WIDTH-1:0] coil_current,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [DUTY_W-1:0]              duty_cycle,
  output logic signed [OUT_W-1:0]        current_reference,
  output logic                           integral_saturated,
  output logic                           duty_saturated,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data
);

  logic signed [SAMPLE_WIDTH-1:0] vref;
  cfg_t                           cfg;
  ctrl_t                          ctrl;

  cvcdc_cfg_regs #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .vref      (vref),
    .cfg       (cfg)
  );

  cvcdc_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctrl      (ctrl)
  );

  cvcdc_datapath #(
    .SAMPLE_WIDTH      (SAMPLE_WIDTH),
    .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .ctrl              (ctrl),
    .cfg               (cfg),
    .vref              (vref),
    .output_voltage    (output_voltage),
    .coil_current      (coil_current),
    .duty_cycle        (duty_cycle),
    .current_reference (current_reference),
    .integral_saturated(integral_saturated),
    .duty_saturated    (duty_saturated)
  );

endmodule

// ===== src/cvcdc_cfg_regs.sv =====
module cvcdc_cfg_regs import cvcdc_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data,
  output logic signed [SAMPLE_WIDTH-1:0] vref,
  output cfg_t                           cfg
);

  localparam int SF = SAMPLE_WIDTH - 8;
  localparam logic [SAMPLE_WIDTH-1:0] RST_VREF =
    SAMPLE_WIDTH'(RST_VREF_UNITS * (2 ** SF));
  localparam logic [LIMIT_W-1:0] RST_ILIM = LIMIT_W'(RST_ILIM_UNITS * (2 ** SF));
  localparam logic [LIMIT_W-1:0] RST_CLIM = LIMIT_W'(RST_CLIM_UNITS * (2 ** SF));

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vref           <= RST_VREF;
      cfg.kp_v       <= RST_KP_V;
      cfg.ki_v       <= RST_KI_V;
      cfg.kp_i       <= RST_KP_I;
      cfg.int_limit  <= RST_ILIM;
      cfg.cur_limit  <= RST_CLIM;
      cfg.duty_ceil  <= RST_DUTY_MAX;
      cfg.duty_floor <= RST_DUTY_MIN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_e'(cfg_index))
        REG_VOLTAGE_REFERENCE: vref           <= cfg_data[SAMPLE_WIDTH-1:0];
        REG_VOLTAGE_PROP_GAIN: cfg.kp_v       <= cfg_data[GAIN_W-1:0];
        REG_VOLTAGE_INT_GAIN:  cfg.ki_v       <= cfg_data[GAIN_W-1:0];
        REG_CURRENT_PROP_GAIN: cfg.kp_i       <= cfg_data[GAIN_W-1:0];
        REG_INTEGRAL_LIMIT:    cfg.int_limit  <= cfg_data[LIMIT_W-1:0];
        REG_CURRENT_LIMIT:     cfg.cur_limit  <= cfg_data[LIMIT_W-1:0];
        REG_DUTY_MAXIMUM:      cfg.duty_ceil  <= cfg_data[DUTY_W-1:0];
        REG_DUTY_MINIMUM:      cfg.duty_floor <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/cvcdc_datapath.sv =====
module cvcdc_datapath import cvcdc_pkg::*; #(
  parameter int SAMPLE_WIDTH       = 16,
  parameter int GAIN_FRACTION_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ctrl_t                          ctrl,
  input  cfg_t                           cfg,
  input  logic signed [SAMPLE_WIDTH-1:0] vref,
  input  logic signed [SAMPLE_WIDTH-1:0] output_voltage,
  input  logic signed [SAMPLE_WIDTH-1:0] coil_current,
  output logic [DUTY_W-1:0]              duty_cycle,
  output logic signed [OUT_W-1:0]        current_reference,
  output logic                           integral_saturated,
  output logic                           duty_saturated
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int G   = GAIN_FRACTION_BITS;
  localparam int SF  = SW - 8;
  localparam int MA  = ((SW > OUT_W) ? SW : OUT_W) + 1;
  localparam int MB  = GAIN_W + 1;
  localparam int PW  = MA + MB;
  localparam int ILW = LIMIT_W + G + 1;
  localparam int AW  = ((PW > ILW) ? PW : ILW) + 1;
  localparam int DUTY_SHIFT = G + SF - DUTY_W;

  logic signed [MA-1:0]    err;
  logic signed [MA-1:0]    cerr;
  logic signed [SW-1:0]    cur;
  logic signed [PW-1:0]    prod;
  logic signed [ILW-1:0]   acc;
  logic signed [OUT_W-1:0] iref;
  logic                    isat;

  logic signed [MA-1:0]    mul_a;
  logic [GAIN_W-1:0]       mul_g;
  logic signed [PW-1:0]    mul_p;

  logic signed [AW-1:0]    sum;
  logic signed [AW-1:0]    ilim;
  logic signed [AW-1:0]    acc_next;
  logic                    isat_next;
  logic signed [AW-1:0]    rsh;
  logic signed [AW-1:0]    clim;
  logic signed [AW-1:0]    iref_next;

  logic signed [PW-1:0]    dsh;
  logic signed [PW:0]      dval;
  logic signed [PW:0]      dmax;
  logic signed [PW:0]      dmin;
  logic signed [PW:0]      duty_next;
  logic                    dsat_next;

  // Shared multiplier: signed operand times zero-extended gain
  assign mul_a = ctrl.mul_cerr ? cerr : err;

  always_comb begin
    case (ctrl.gain_sel)
      GAIN_KI:  mul_g = cfg.ki_v;
      GAIN_KP:  mul_g = cfg.kp_v;
      GAIN_KPI: mul_g = cfg.kp_i;
      default:  mul_g = '0;
    endcase
  end

  assign mul_p = mul_a * $signed({1'b0, mul_g});

  // One adder serves the integral step and the reference sum
  assign sum = $signed({{(AW-ILW){acc[ILW-1]}}, acc}) +
               $signed({{(AW-PW){prod[PW-1]}}, prod});

  assign ilim = $signed({{(AW-LIMIT_W-G){1'b0}}, cfg.int_limit, {G{1'b0}}});

  always_comb begin
    acc_next  = sum;
    isat_next = 1'b0;
    if (sum > ilim) begin
      acc_next  = ilim;
      isat_next = 1'b1;
    end else if (sum < -ilim) begin
      acc_next  = -ilim;
      isat_next = 1'b1;
    end
  end

  assign rsh  = sum >>> G;
  assign clim = $signed({{(AW-LIMIT_W){1'b0}}, cfg.cur_limit});

  always_comb begin
    iref_next = rsh;
    if (rsh > clim) begin
      iref_next = clim;
    end else if (rsh < -clim) begin
      iref_next = -clim;
    end
  end

  assign dsh  = prod >>> DUTY_SHIFT;
  assign dval = $signed({dsh[PW-1], dsh}) + $signed({{(PW+1-DUTY_W){1'b0}}, DUTY_HALF});
  assign dmax = $signed({{(PW+1-DUTY_W){1'b0}}, cfg.duty_ceil});
  assign dmin = $signed({{(PW+1-DUTY_W){1'b0}}, cfg.duty_floor});

  // Maximum clamp first, then minimum
  always_comb begin
    duty_next = dval;
    dsat_next = 1'b0;
    if (dval > dmax) begin
      duty_next = dmax;
      dsat_next = 1'b1;
    end
    if (duty_next < dmin) begin
      duty_next = dmin;
      dsat_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctrl.int_en) begin
      acc <= acc_next[ILW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      err <= $signed({{(MA-SW){vref[SW-1]}}, vref}) -
             $signed({{(MA-SW){output_voltage[SW-1]}}, output_voltage});
      cur <= coil_current;
    end
    if (ctrl.mul_en) begin
      prod <= mul_p;
    end
    // Hold the flag inside until the result register loads
    if (ctrl.int_en) begin
      isat <= isat_next;
    end
    if (ctrl.ref_en) begin
      iref <= iref_next[OUT_W-1:0];
    end
    if (ctrl.cerr_en) begin
      cerr <= $signed({{(MA-OUT_W){iref[OUT_W-1]}}, iref}) -
              $signed({{(MA-SW){cur[SW-1]}}, cur});
    end
    if (ctrl.out_en) begin
      duty_cycle         <= duty_next[DUTY_W-1:0];
      current_reference  <= iref;
      integral_saturated <= isat;
      duty_saturated     <= dsat_next;
    end
  end

endmodule

// ===== src/cvcdc_seq.sv =====
module cvcdc_seq import cvcdc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  output ctrl_t ctrl
);

  state_e state;
  state_e state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    ctrl       = '0;
    ctrl.gain_sel = GAIN_KI;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.load_in = 1'b1;
          state_next   = S_MI;
        end
      end
      S_MI: begin
        ctrl.mul_en   = 1'b1;
        ctrl.gain_sel = GAIN_KI;
        state_next    = S_INT;
      end
      S_INT: begin
        // Integrate the ki product while the kp product forms
        ctrl.int_en   = 1'b1;
        ctrl.mul_en   = 1'b1;
        ctrl.gain_sel = GAIN_KP;
        state_next    = S_REF;
      end
      S_REF: begin
        ctrl.ref_en = 1'b1;
        state_next  = S_CERR;
      end
      S_CERR: begin
        ctrl.cerr_en = 1'b1;
        state_next   = S_MC;
      end
      S_MC: begin
        ctrl.mul_en   = 1'b1;
        ctrl.mul_cerr = 1'b1;
        ctrl.gain_sel = GAIN_KPI;
        state_next    = S_DUTY;
      end
      S_DUTY: begin
        // Hold here until the result register can take the item
        if (out_free) begin
          ctrl.out_en = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.out_en) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/cvcdc_checker.sv =====
module cvcdc_props import cvcdc_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [DUTY_W-1:0]       duty_cycle,
  input logic signed [OUT_W-1:0] current_reference
);

  // Busy through S_MI, S_INT and S_REF after an item enters
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall ##1 in_stall ##1 in_stall)
    else $error("input taken again too soon after an item");

  // The symmetric clamp never yields the most negative code
  a_iref_symmetric: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (current_reference != 16'sh8000))
    else $error("current reference outside its symmetric clamp");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(duty_cycle) && $stable(current_reference)))
    else $error("stalled result changed");

endmodule

bind cascaded_voltage_current_duty_control cvcdc_props u_props (.*);

// ===== verif/cvcdc_checker.sv =====
`timescale 1ns / 100ps

module cvcdc_checker import cvcdc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic signed [15:0]    output_voltage,
  input  logic signed [15:0]    coil_current,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [DUTY_W-1:0]     duty_cycle,
  input  logic signed [OUT_W-1:0] current_reference,
  input  logic                  integral_saturated,
  input  logic                  duty_saturated,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    outstanding
);

  localparam int SAMPLE_FRAC = 8;
  localparam int GAIN_FRAC   = 24;
  localparam int DUTY_SHIFT  = GAIN_FRAC + SAMPLE_FRAC - 16;

  typedef struct packed {
    logic [DUTY_W-1:0]       duty;
    logic signed [OUT_W-1:0] iref;
    logic                    isat;
    logic                    dsat;
  } duty_result_t;

  // Own copy of the registers and of the integral
  logic signed [15:0]  v_ref;
  logic [GAIN_W-1:0]   kp_v, ki_v, kp_i;
  logic [LIMIT_W-1:0]  int_lim, cur_lim;
  logic [DUTY_W-1:0]   d_max, d_min;
  longint              integ;

  duty_result_t        awaited_results[$];
  duty_result_t        want, got;
  int                  fails = 0;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic step_controller(input logic signed [15:0] volt,
                                 input logic signed [15:0] amps,
                                 output duty_result_t r);
    longint err, bound, sum, iref, cerr, duty;
    r = '0;
    err   = longint'(v_ref) - longint'(volt);
    bound = longint'(int_lim) <<< GAIN_FRAC;
    sum   = integ + err * longint'(ki_v);
    if (sum > bound) begin
      sum = bound;
      r.isat = 1'b1;
    end
    if (sum < -bound) begin
      sum = -bound;
      r.isat = 1'b1;
    end
    integ = sum;
    iref = (err * longint'(kp_v) + sum) >>> GAIN_FRAC;
    if (iref > longint'(cur_lim)) iref = longint'(cur_lim);
    if (iref < -longint'(cur_lim)) iref = -longint'(cur_lim);
    cerr = iref - longint'(amps);
    duty = longint'(DUTY_HALF) + ((cerr * longint'(kp_i)) >>> DUTY_SHIFT);
    // maximum first, then minimum, so a crossed pair ends at the minimum
    if (duty > longint'(d_max)) begin
      duty = longint'(d_max);
      r.dsat = 1'b1;
    end
    if (duty < longint'(d_min)) begin
      duty = longint'(d_min);
      r.dsat = 1'b1;
    end
    r.duty = duty[15:0];
    r.iref = iref[15:0];
  endtask

  always @(posedge clk) begin
    if (rst) begin
      v_ref   = 16'(RST_VREF_UNITS <<< SAMPLE_FRAC);
      kp_v    = RST_KP_V;
      ki_v    = RST_KI_V;
      kp_i    = RST_KP_I;
      int_lim = 15'(RST_ILIM_UNITS <<< SAMPLE_FRAC);
      cur_lim = 15'(RST_CLIM_UNITS <<< SAMPLE_FRAC);
      d_max   = RST_DUTY_MAX;
      d_min   = RST_DUTY_MIN;
      integ   = 0;
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_e'(cfg_index))
          REG_VOLTAGE_REFERENCE: v_ref   = cfg_data[15:0];
          REG_VOLTAGE_PROP_GAIN: kp_v    = cfg_data[GAIN_W-1:0];
          REG_VOLTAGE_INT_GAIN:  ki_v    = cfg_data[GAIN_W-1:0];
          REG_CURRENT_PROP_GAIN: kp_i    = cfg_data[GAIN_W-1:0];
          REG_INTEGRAL_LIMIT:    int_lim = cfg_data[LIMIT_W-1:0];
          REG_CURRENT_LIMIT:     cur_lim = cfg_data[LIMIT_W-1:0];
          REG_DUTY_MAXIMUM:      d_max   = cfg_data[DUTY_W-1:0];
          REG_DUTY_MINIMUM:      d_min   = cfg_data[DUTY_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = '{duty_cycle, current_reference, integral_saturated, duty_saturated};
        if (awaited_results.size() == 0) begin
          $display("%0t: result with none awaited: duty %0d iref %0d", $time,
                   duty_cycle, current_reference);
          fails++;
        end else begin
          want = awaited_results.pop_front();
          if (got.duty !== want.duty) begin
            $display("%0t: duty_cycle expected %0d got %0d", $time, want.duty, got.duty);
            fails++;
          end
          if (got.iref !== want.iref) begin
            $display("%0t: current_reference expected %0d got %0d", $time,
                     want.iref, got.iref);
            fails++;
          end
          if (got.isat !== want.isat) begin
            $display("%0t: integral_saturated expected %0b got %0b", $time,
                     want.isat, got.isat);
            fails++;
          end
          if (got.dsat !== want.dsat) begin
            $display("%0t: duty_saturated expected %0b got %0b", $time,
                     want.dsat, got.dsat);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        step_controller(output_voltage, coil_current, want);
        awaited_results.push_back(want);
      end
    end
    fail_count  <= fails;
    outstanding <= awaited_results.size();
  end

endmodule

// ===== verif/tb_cascaded_voltage_current_duty_control.sv =====
`timescale 1ns / 100ps

module tb_cascaded_voltage_current_duty_control;
  import cvcdc_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int NUM_PHASES  = 12;
  localparam int PHASE_ITEMS = 95;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [15:0]      output_voltage = '0;
  logic signed [15:0]      coil_current = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [DUTY_W-1:0]       duty_cycle;
  logic signed [OUT_W-1:0] current_reference;
  logic                    integral_saturated;
  logic                    duty_saturated;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  int                      fail_count;
  int                      outstanding;
  int                      cycles = 0;
  int                      stall_left = 0;
  int                      stall_draw;
  bit                      tx_idle = 1'b0;
  bit                      rx_idle = 1'b0;
  logic [CFG_DATA_W-1:0]   next_cfg [8];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  cascaded_voltage_current_duty_control u_dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .output_voltage     (output_voltage),
    .coil_current       (coil_current),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .duty_cycle         (duty_cycle),
    .current_reference  (current_reference),
    .integral_saturated (integral_saturated),
    .duty_saturated     (duty_saturated),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  cvcdc_checker u_check (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .output_voltage     (output_voltage),
    .coil_current       (coil_current),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .duty_cycle         (duty_cycle),
    .current_reference  (current_reference),
    .integral_saturated (integral_saturated),
    .duty_saturated     (duty_saturated),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .fail_count         (fail_count),
    .outstanding        (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** cascaded_voltage_current_duty_control: FAILED **");
      $finish;
    end
  end

  // Draw a stall length after every taken result, count it down
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      stall_draw = rx_idle ? $urandom_range(0, 17) : 0;
      stall_left <= stall_draw;
      out_stall  <= (stall_draw != 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end
  end

  // Keep valid high across back-to-back items; drop it only for a gap
  task automatic send_sample(input logic signed [15:0] volt,
                             input logic signed [15:0] amps);
    int gap;
    gap = tx_idle ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    output_voltage <= volt;
    coil_current   <= amps;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic load_settings();
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= next_cfg[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] raw;
    logic signed [15:0]    cur_vref;
    logic signed [15:0]    vs, cs;
    int                    sel, vi;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: rail-to-rail samples and zero voltage error
    send_sample(16'sh7FFF, 16'sh0000);
    send_sample(-16'sh8000, 16'sh0000);
    send_sample(-16'sd3072, 16'sh0000);
    send_sample(16'sh0000, 16'sh7FFF);
    send_sample(16'sh0000, -16'sh8000);
    send_sample(-16'sh8000, -16'sh8000);
    send_sample(16'sh7FFF, 16'sh7FFF);
    drain();

    // full-scale gains and limits: drive the integral into both clamps
    next_cfg[REG_VOLTAGE_REFERENCE] = 24'h000000;
    next_cfg[REG_VOLTAGE_PROP_GAIN] = 24'hFFFFFF;
    next_cfg[REG_VOLTAGE_INT_GAIN]  = 24'hFFFFFF;
    next_cfg[REG_CURRENT_PROP_GAIN] = 24'hFFFFFF;
    next_cfg[REG_INTEGRAL_LIMIT]    = 24'h007FFF;
    next_cfg[REG_CURRENT_LIMIT]     = 24'h007FFF;
    next_cfg[REG_DUTY_MAXIMUM]      = 24'h00FFFF;
    next_cfg[REG_DUTY_MINIMUM]      = 24'h000000;
    load_settings();
    send_sample(16'sh7FFF, -16'sh8000);
    send_sample(16'sh7FFF, -16'sh8000);
    send_sample(-16'sh8000, 16'sh7FFF);
    send_sample(-16'sh8000, 16'sh7FFF);
    send_sample(16'sh0000, 16'sh0000);
    send_sample(16'sh0001, -16'sh0001);
    drain();

    // duty minimum above maximum, zero integral and current limits
    next_cfg[REG_VOLTAGE_REFERENCE] = 24'h00F400;
    next_cfg[REG_VOLTAGE_PROP_GAIN] = 24'd1677722;
    next_cfg[REG_VOLTAGE_INT_GAIN]  = 24'd2517;
    next_cfg[REG_CURRENT_PROP_GAIN] = 24'd838861;
    next_cfg[REG_INTEGRAL_LIMIT]    = 24'h000000;
    next_cfg[REG_CURRENT_LIMIT]     = 24'h000000;
    next_cfg[REG_DUTY_MAXIMUM]      = 24'd10000;
    next_cfg[REG_DUTY_MINIMUM]      = 24'd50000;
    load_settings();
    send_sample(16'sh0000, 16'sh0000);
    send_sample(16'sh7FFF, -16'sh8000);
    send_sample(-16'sh8000, 16'sh7FFF);
    drain();

    // zero gains and a zero-width duty window
    next_cfg[REG_VOLTAGE_REFERENCE] = 24'hFF7FFF;
    next_cfg[REG_VOLTAGE_PROP_GAIN] = 24'h000000;
    next_cfg[REG_VOLTAGE_INT_GAIN]  = 24'h000000;
    next_cfg[REG_CURRENT_PROP_GAIN] = 24'h000000;
    next_cfg[REG_INTEGRAL_LIMIT]    = 24'hFF8000;
    next_cfg[REG_CURRENT_LIMIT]     = 24'hFF8000;
    next_cfg[REG_DUTY_MAXIMUM]      = 24'hFF0000;
    next_cfg[REG_DUTY_MINIMUM]      = 24'hFF0000;
    load_settings();
    send_sample(-16'sh8000, 16'sh7FFF);
    send_sample(16'sh7FFF, -16'sh8000);
    drain();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      for (int i = 0; i < 8; i++) begin
        raw = CFG_DATA_W'($urandom());  // bits above the register width stay random
        sel = $urandom_range(0, 9);
        case (cfg_reg_e'(i))
          REG_VOLTAGE_REFERENCE: begin
            if (sel == 0) raw[15:0] = 16'h8000;
            else if (sel == 1) raw[15:0] = 16'h7FFF;
            else if (sel > 3) raw[15:0] = 16'($urandom_range(0, 12000) - 6000);
          end
          REG_VOLTAGE_PROP_GAIN, REG_VOLTAGE_INT_GAIN, REG_CURRENT_PROP_GAIN: begin
            if (sel == 0) raw = '0;
            else if (sel == 1) raw = 24'hFFFFFF;
            else if (sel > 3) raw = 24'($urandom_range(0, 24'h1FFFFF));
          end
          REG_INTEGRAL_LIMIT, REG_CURRENT_LIMIT: begin
            if (sel == 0) raw[14:0] = '0;
            else if (sel == 1) raw[14:0] = 15'h7FFF;
            else if (sel > 4) raw[14:0] = 15'($urandom_range(0, 3000));
          end
          REG_DUTY_MAXIMUM: begin
            if (sel == 0) raw[15:0] = 16'hFFFF;
            else if (sel == 1) raw[15:0] = '0;
            else if (sel > 3) raw[15:0] = 16'($urandom_range(40000, 65535));
          end
          REG_DUTY_MINIMUM: begin
            if (sel == 0) raw[15:0] = '0;
            else if (sel == 1) raw[15:0] = 16'hFFFF;
            else if (sel > 3) raw[15:0] = 16'($urandom_range(0, 25000));
          end
          default: ;
        endcase
        next_cfg[i] = raw;
      end
      load_settings();
      cur_vref = next_cfg[REG_VOLTAGE_REFERENCE][15:0];
      tx_idle  = (phase % 3) != 0;
      rx_idle  = (phase % 4) != 1;

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (phase == 0 && k == 40) drain();
        if ($urandom_range(0, 9) < 6) begin
          // hold the voltage near its target so the loops stay out of the clamps
          vi = int'(cur_vref) + int'($urandom_range(0, 1024)) - 512;
          if (vi > 32767) vi = 32767;
          if (vi < -32768) vi = -32768;
          vs = vi[15:0];
          cs = 16'($urandom_range(0, 3000) - 1500);
        end else begin
          vs = 16'($urandom());
          cs = 16'($urandom());
        end
        send_sample(vs, cs);
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("** cascaded_voltage_current_duty_control: PASSED **");
    end else begin
      $display("** cascaded_voltage_current_duty_control: FAILED **");
    end
    $finish;
  end

endmodule
